[rtl/lzwd_pkg.sv]
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the fixed 9-bit LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;
  localparam int OUT_LEN    = 484;
  localparam int DICT_DEPTH = 256;
  localparam int MAX_EXP    = 30;
  localparam int PW         = $clog2(OUT_LEN + 1);
  localparam int AW         = $clog2(OUT_LEN);
  localparam int DW         = $clog2(DICT_DEPTH + 1);
  localparam int DIW        = $clog2(DICT_DEPTH);
  localparam int LW         = PW;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_PREMAT   = 3'd4;

  localparam logic [8:0] CODE_CLEAR = 9'h100;
  localparam logic [8:0] CODE_END   = 9'h101;
  localparam logic [8:0] CODE_BASE  = 9'h102;

  typedef struct packed {
    logic       has_code;
    logic [8:0] code;
    logic       last;
  } cmd_t;
endpackage

[rtl/lzwd_if.sv]
// ----------------------------------------------------------------------------
// lzwd_in_if / lzwd_out_if
// Valid/ready channels for payload words and decoded results.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;
  modport source (output valid, in_byte, final_byte, input ready);
  modport sink   (input valid, in_byte, final_byte, output ready);
endinterface

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic [2:0] status;
  modport source (output valid, out_byte, byte_valid, run_last, status, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, status, output ready);
endinterface

[rtl/lzw_decompressor_9bit_fixed_core.sv]
// ----------------------------------------------------------------------------
// lzw_decompressor_9bit_fixed_core
// Fixed 9-bit LZW decoder producing at most one pixel word per result.
// ----------------------------------------------------------------------------
// A payload word is taken by the unpacker and queued; the decoder takes a
// new code only once it is done with the last. The first code and a literal
// are emitted directly; a dictionary code is looked up and its bytes are then
// emitted one at a time, each read through the single read port of the output
// store. Status results, end and reserved codes, codes past the dictionary,
// and words without a complete code or ignored after a status are handled
// too. Stalls on the result side hold the decoder in all of these.
module lzw_decompressor_9bit_fixed_core import lzwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lzwd_in_if.sink    in_ch,
  lzwd_out_if.source out_ch
);
  logic cv, cr, qv, qr;
  cmd_t cm, qc;

  lzwd_unpack u_unp (.clk, .rst_n, .in_ch, .cmd_valid(cv), .cmd_ready(cr), .cmd(cm));
  lzwd_queue u_q (.clk, .rst_n, .push_valid(cv), .push_ready(cr), .push_cmd(cm),
                  .pop_valid(qv), .pop_ready(qr), .pop_cmd(qc));
  lzwd_decode u_dec (.clk, .rst_n, .cmd_valid(qv), .cmd_ready(qr), .cmd(qc), .out_ch);
endmodule

[rtl/lzwd_unpack.sv]
// ----------------------------------------------------------------------------
// lzwd_unpack
// Front end: gathers payload words LSB-first into 9-bit codes.
// ----------------------------------------------------------------------------
module lzwd_unpack import lzwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lzwd_in_if.sink    in_ch,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);
  logic [15:0] acc_r;
  logic [4:0]  held_r;
  logic [15:0] merged;
  logic [4:0]  held8;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign held8       = held_r + 5'd8;
  assign merged      = acc_r | (16'(in_ch.in_byte) << held_r[3:0]);
  assign cmd.has_code = held8 >= 5'd9;
  assign cmd.code     = merged[8:0];
  assign cmd.last     = in_ch.final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
    end else if (in_ch.valid && cmd_ready) begin
      if (in_ch.final_byte) begin
        acc_r  <= '0;
        held_r <= '0;
      end else if (cmd.has_code) begin
        acc_r  <= merged >> 9;
        held_r <= held8 - 5'd9;
      end else begin
        acc_r  <= merged;
        held_r <= held8;
      end
    end
  end
endmodule

[rtl/lzwd_queue.sv]
// ----------------------------------------------------------------------------
// lzwd_queue
// Two-entry command queue between unpacker and decoder.
// ----------------------------------------------------------------------------
module lzwd_queue import lzwd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_cmd    = mem_r[rp_r];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/lzwd_decode.sv]
// ----------------------------------------------------------------------------
// lzwd_decode
// Back end: dictionary lookup, byte expansion from the output store and
// status reporting.
// ----------------------------------------------------------------------------
module lzwd_decode import lzwd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  cmd_t     cmd,
  lzwd_out_if.source out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_STAT = 3'd5;
  localparam logic [2:0] S_LIT  = 3'd6;
  localparam logic [2:0] S_FIT  = 3'd7;

  logic [7:0]  store_r [OUT_LEN];
  logic [AW-1:0] dst_r [DICT_DEPTH];
  logic [LW-1:0] dln_r [DICT_DEPTH];

  logic [2:0]  state_r;
  logic [PW-1:0] wpos_r;
  logic [DW-1:0] dcnt_r;
  logic [AW-1:0] pst_r;
  logic [LW-1:0] pln_r;
  logic        first_r, fin_r;
  cmd_t        c_r;
  logic        kwk_r;
  logic [AW-1:0] s_r, rdp_r;
  logic [LW-1:0] l_r, i_r;
  logic [AW-1:0] ls_rd;
  logic [LW-1:0] ll_rd;
  logic [7:0]  rd_q, first_q;
  logic [2:0]  st_r;
  logic        ov_valid_r, ov_bv_r, ov_last_r;
  logic [7:0]  ov_byte_r;
  logic [2:0]  ov_st_r;
  logic        ov_free;
  logic [PW:0] need;
  logic        fits_ok;
  logic [8:0]  idx9;
  logic        add_en;
  logic [AW-1:0] add_s;
  logic [LW-1:0] add_l;

  assign ov_free  = !ov_valid_r || out_ch.ready;
  assign cmd_ready = state_r == S_IDLE && ov_free;
  assign out_ch.valid      = ov_valid_r;
  assign out_ch.out_byte   = ov_byte_r;
  assign out_ch.byte_valid = ov_bv_r;
  assign out_ch.run_last   = ov_last_r;
  assign out_ch.status     = ov_st_r;
  assign idx9 = c_r.code - CODE_BASE;
  assign need = (PW+1)'(wpos_r) + (PW+1)'(l_r);
  assign fits_ok = need <= (PW+1)'(OUT_LEN) && l_r <= LW'(MAX_EXP);

  always_ff @(posedge clk) begin
    ls_rd <= dst_r[idx9[DIW-1:0]];
    ll_rd <= dln_r[idx9[DIW-1:0]];
    rd_q  <= store_r[rdp_r];
    if (add_en && dcnt_r < DW'(DICT_DEPTH)) begin
      dst_r[dcnt_r[DIW-1:0]] <= add_s;
      dln_r[dcnt_r[DIW-1:0]] <= add_l;
    end
  end

  always_comb begin
    add_en = 1'b0;
    add_s  = pst_r;
    add_l  = pln_r + LW'(1);
    if (state_r == S_FIT && fits_ok) add_en = 1'b1;
    if (state_r == S_LIT && ov_free && fits_ok) add_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; wpos_r <= '0; dcnt_r <= '0; pst_r <= '0; pln_r <= '0;
      first_r <= 1'b1; fin_r <= 1'b0; ov_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) ov_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (cmd_valid && ov_free) begin
          c_r <= cmd;
          st_r <= ST_RUN;
          if (fin_r) begin
            if (cmd.last) begin
              fin_r <= 1'b0; first_r <= 1'b1; wpos_r <= '0; dcnt_r <= '0;
              pst_r <= '0; pln_r <= '0;
            end
          end else if (!cmd.has_code) begin
            if (cmd.last) begin
              st_r <= first_r ? ST_PREMAT
                    : (wpos_r == PW'(OUT_LEN) ? ST_DONE : ST_PREMAT);
              state_r <= S_STAT;
            end
          end else if (first_r) begin
            first_r <= 1'b0;
            store_r[0] <= cmd.code[7:0];
            wpos_r <= PW'(1); pst_r <= '0; pln_r <= LW'(1);
            ov_valid_r <= 1'b1; ov_byte_r <= cmd.code[7:0]; ov_bv_r <= 1'b1;
            ov_st_r <= ST_RUN; ov_last_r <= !cmd.last;
            if (cmd.last) begin
              st_r <= ST_PREMAT; state_r <= S_STAT;
            end
          end else if (cmd.code <= 9'h0ff) begin
            l_r <= LW'(1); state_r <= S_LIT;
          end else if (cmd.code == CODE_END) begin
            st_r <= wpos_r == PW'(OUT_LEN) ? ST_DONE : ST_PREMAT; state_r <= S_STAT;
          end else if (cmd.code == CODE_CLEAR ||
                       9'(cmd.code - CODE_BASE) >= 9'(DICT_DEPTH)) begin
            st_r <= ST_INVALID; state_r <= S_STAT;
          end else begin
            state_r <= S_LOOK;
          end
        end
        S_LIT: if (ov_free) begin
          if (!fits_ok) begin
            st_r <= ST_OVERFLOW; state_r <= S_STAT;
          end else begin
            store_r[wpos_r[AW-1:0]] <= c_r.code[7:0];
            if (dcnt_r < DW'(DICT_DEPTH)) dcnt_r <= dcnt_r + DW'(1);
            pst_r <= wpos_r[AW-1:0]; pln_r <= LW'(1);
            wpos_r <= wpos_r + PW'(1);
            ov_valid_r <= 1'b1; ov_byte_r <= c_r.code[7:0]; ov_bv_r <= 1'b1;
            ov_st_r <= ST_RUN; ov_last_r <= 1'b0;
            if (c_r.last) begin
              st_r <= (wpos_r + PW'(1)) == PW'(OUT_LEN) ? ST_DONE : ST_PREMAT;
              state_r <= S_STAT;
            end else begin
              ov_last_r <= 1'b1; state_r <= S_IDLE;
            end
          end
        end
        S_LOOK: begin
          if (DW'(idx9) < dcnt_r) begin
            kwk_r <= 1'b0; state_r <= S_CHK;
          end else if (DW'(idx9) == dcnt_r) begin
            kwk_r <= 1'b1; state_r <= S_CHK;
          end else begin
            st_r <= ST_INVALID; state_r <= S_STAT;
          end
        end
        S_CHK: begin
          if (kwk_r) begin
            s_r <= pst_r; l_r <= pln_r + LW'(1);
          end else begin
            s_r <= ls_rd; l_r <= ll_rd;
          end
          state_r <= S_FIT;
        end
        S_FIT: begin
          if (!fits_ok) begin
            st_r <= ST_OVERFLOW; state_r <= S_STAT;
          end else begin
            if (dcnt_r < DW'(DICT_DEPTH)) dcnt_r <= dcnt_r + DW'(1);
            pst_r <= wpos_r[AW-1:0]; pln_r <= l_r;
            i_r <= '0; rdp_r <= s_r; state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EMIT;
        S_EMIT: if (ov_free) begin
          if (i_r == '0) first_q <= rd_q;
          ov_valid_r <= 1'b1; ov_bv_r <= 1'b1; ov_st_r <= ST_RUN;
          ov_byte_r <= (kwk_r && i_r == l_r - LW'(1)) ? first_q : rd_q;
          store_r[wpos_r[AW-1:0]] <=
            (kwk_r && i_r == l_r - LW'(1)) ? first_q : rd_q;
          wpos_r <= wpos_r + PW'(1);
          i_r <= i_r + LW'(1);
          rdp_r <= (rdp_r == AW'(OUT_LEN - 1)) ? '0 : rdp_r + AW'(1);
          ov_last_r <= 1'b0;
          if (i_r == l_r - LW'(1)) begin
            if (c_r.last) begin
              st_r <= (wpos_r + PW'(1)) == PW'(OUT_LEN) ? ST_DONE : ST_PREMAT;
              state_r <= S_STAT;
            end else begin
              ov_last_r <= 1'b1; state_r <= S_IDLE;
            end
          end else state_r <= S_RD;
        end
        S_STAT: if (ov_free) begin
          ov_valid_r <= 1'b1; ov_bv_r <= 1'b0; ov_byte_r <= '0;
          ov_st_r <= st_r; ov_last_r <= 1'b1;
          state_r <= S_IDLE;
          if (c_r.last) begin
            fin_r <= 1'b0; first_r <= 1'b1; wpos_r <= '0; dcnt_r <= '0;
            pst_r <= '0; pln_r <= '0;
          end else fin_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/lzwd_checker.sv]
// ----------------------------------------------------------------------------
// lzwd_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module lzwd_checker import lzwd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       valid,
  input logic       ready,
  input logic       byte_valid,
  input logic [7:0] out_byte,
  input logic [2:0] status
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid && !ready |=> valid && $stable(out_byte) && $stable(status))
    else $error("result changed while stalled");
  a_byte_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid && byte_valid |-> status == ST_RUN) else $error("byte with status");
  a_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid && !byte_valid |-> out_byte == 8'd0 && status != ST_RUN)
    else $error("bad status result");
endmodule

bind lzw_decompressor_9bit_fixed_core lzwd_checker u_chk (
  .clk, .rst_n, .valid(out_ch.valid), .ready(out_ch.ready),
  .byte_valid(out_ch.byte_valid), .out_byte(out_ch.out_byte), .status(out_ch.status));
